FILE: hw/rtl/per_domain_memory_quota_tracker_top_assert.svh
// Assertion macros shared by the quota tracker RTL.
`ifndef PER_DOMAIN_MEMORY_QUOTA_TRACKER_TOP_ASSERT_SVH
`define PER_DOMAIN_MEMORY_QUOTA_TRACKER_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define PDQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pdq_pkg.sv
// Shared constants, tables and types of the quota tracker.
package pdq_pkg;

	localparam int FIELD_W = 40;
	localparam int DOMAIN_FIELD_W = 3;
	localparam int DOMAIN_COUNT_DEF = 8;
	localparam int BYTE_WIDTH_DEF = 40;
	localparam int MAX_DOMAINS = 16;

	// Percent shares; slots past the eighth get nothing.
	localparam int PCT_W = 5;
	localparam logic [PCT_W-1:0] SHARE_PCT [MAX_DOMAINS] = '{
		5'd30, 5'd10, 5'd25, 5'd8, 5'd7, 5'd6, 5'd8, 5'd6,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
	};

	// Divide by 100: remainder fits in REM_W bits.
	localparam int PCT_DIVISOR = 100;
	localparam int REM_W = 7;

	// floor(x / 100) for x < 25600 as (x * FRAC_RECIP) >> FRAC_SHIFT.
	localparam int FRAC_RECIP = 5243;
	localparam int FRAC_SHIFT = 19;
	localparam int FRAC_PROD_W = 25;

	// Budget divide by 100: one DIG_W-bit digit per cycle, digit quotient by reciprocal.
	localparam int DIG_W = 8;
	localparam int DIG_PROD_W = 28;

	// Critical test: used * CRIT_USE_MUL > limit * CRIT_LIM_MUL.
	localparam int CRIT_USE_MUL = 10;
	localparam int CRIT_LIM_MUL = 9;
	localparam int CRIT_EXTRA_W = 4;

	typedef enum logic [1:0] {
		CAL_IDLE,
		CAL_DIV,
		CAL_LIM,
		CAL_LIM9
	} cal_state_t;

	typedef struct packed {
		logic busy;
		logic div_step;
		logic lim_load;
		logic lim9_load;
	} cal_ctl_t;

endpackage

FILE: hw/rtl/pdq_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface pdq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                new_frame;
	logic [pdq_pkg::DOMAIN_FIELD_W-1:0]  domain;
	logic [pdq_pkg::FIELD_W-1:0]         request_bytes;

	modport source (output valid, output new_frame, output domain, output request_bytes,
		input ready);
	modport sink (input valid, input new_frame, input domain, input request_bytes,
		output ready);
endinterface

FILE: hw/rtl/pdq_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
interface pdq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        granted;
	logic [pdq_pkg::FIELD_W-1:0] domain_remaining;
	logic                        domain_critical;
	logic [pdq_pkg::FIELD_W-1:0] total_remaining;

	modport source (output valid, output granted, output domain_remaining,
		output domain_critical, output total_remaining, input ready);
	modport sink (input valid, input granted, input domain_remaining,
		input domain_critical, input total_remaining, output ready);
endinterface

FILE: hw/rtl/per_domain_memory_quota_tracker_top.sv
// Per-domain memory quota tracker: admission control of byte requests per frame.
//
// The tracker keeps per-frame byte usage for DOMAIN_COUNT domains, each limited to a fixed
// percentage of the total budget (30, 10, 25, 8, 7, 6, 8 and 6 percent, rounded down).
// A request is registered on acceptance, then evaluated against its domain's limit and
// charged if it fits once the result register is empty or being drained; its result is
// loaded into the result register at the same edge, and the new usage is seen by the
// request behind it. One request per cycle is sustained while rsp.ready stays high and
// no limit calculation runs. Writing total_budget clears all usage and starts the limit
// calculation: a long divide of the budget by 100, one 8-bit digit per cycle with a
// reciprocal multiply for each digit, followed by a state that forms the limits and one
// that forms the scaled limits for the critical test. During the calculation the request
// channel holds ready low. Critical is the exact integer test used*10 > limit*9.
// total_remaining is kept directly as budget minus charged bytes; it never goes negative
// since the limits sum to at most the budget.

`include "per_domain_memory_quota_tracker_top_assert.svh"

module per_domain_memory_quota_tracker_top #(
	parameter int DOMAIN_COUNT = pdq_pkg::DOMAIN_COUNT_DEF,
	parameter int BYTE_WIDTH = pdq_pkg::BYTE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pdq_pkg::FIELD_W-1:0] cfg_wdata,
	pdq_req_if.sink                     req,
	pdq_rsp_if.source                   rsp
);

	// Values never exceed the budget, which is at most FIELD_W bits wide.
	localparam int VAL_W = (BYTE_WIDTH < pdq_pkg::FIELD_W) ? BYTE_WIDTH : pdq_pkg::FIELD_W;
	localparam int DIV_STEPS = (VAL_W + pdq_pkg::DIG_W - 1) / pdq_pkg::DIG_W;
	localparam int DIV_W = DIV_STEPS * pdq_pkg::DIG_W;
	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int PROD_W = VAL_W + pdq_pkg::PCT_W;
	localparam int SCL_W = VAL_W + pdq_pkg::CRIT_EXTRA_W;
	localparam int TRIAL_W = pdq_pkg::REM_W + pdq_pkg::DIG_W;

	// ------------------------------------------------------------------
	// Limit calculation sequencer
	// ------------------------------------------------------------------
	pdq_pkg::cal_state_t cal_state_q, cal_state_d;
	pdq_pkg::cal_ctl_t   cal_ctl;
	logic [CNT_W-1:0]    cnt_q;

	always_comb begin
		cal_state_d = cal_state_q;
		case (cal_state_q)
			pdq_pkg::CAL_IDLE: cal_state_d = pdq_pkg::CAL_IDLE;
			pdq_pkg::CAL_DIV: begin
				if (cnt_q == '0) begin
					cal_state_d = pdq_pkg::CAL_LIM;
				end
			end
			pdq_pkg::CAL_LIM:  cal_state_d = pdq_pkg::CAL_LIM9;
			pdq_pkg::CAL_LIM9: cal_state_d = pdq_pkg::CAL_IDLE;
			default:           cal_state_d = pdq_pkg::CAL_IDLE;
		endcase
		// A budget write always restarts the calculation.
		if (cfg_we) begin
			cal_state_d = pdq_pkg::CAL_DIV;
		end
	end

	always_comb begin
		cal_ctl = '0;
		case (cal_state_q)
			pdq_pkg::CAL_IDLE: cal_ctl = '0;
			pdq_pkg::CAL_DIV: begin
				cal_ctl.busy     = 1'b1;
				cal_ctl.div_step = 1'b1;
			end
			pdq_pkg::CAL_LIM: begin
				cal_ctl.busy     = 1'b1;
				cal_ctl.lim_load = 1'b1;
			end
			pdq_pkg::CAL_LIM9: begin
				cal_ctl.busy      = 1'b1;
				cal_ctl.lim9_load = 1'b1;
			end
			default: cal_ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_state_q <= pdq_pkg::CAL_IDLE;
			cnt_q       <= '0;
		end else begin
			cal_state_q <= cal_state_d;
			if (cfg_we) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cal_ctl.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Long divide of the budget by 100, one digit per cycle, MSB first.
	// quo_q starts as the zero-extended dividend and fills with quotient
	// digits from the bottom; each digit quotient is a reciprocal multiply.
	// ------------------------------------------------------------------
	logic [DIV_W-1:0]               quo_q;
	logic [pdq_pkg::REM_W-1:0]      rem_q;
	logic [TRIAL_W-1:0]             trial;
	logic [pdq_pkg::DIG_PROD_W-1:0] dig_prod;
	logic [pdq_pkg::DIG_W-1:0]      q_dig;
	logic [pdq_pkg::REM_W-1:0]      rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[DIV_W-1 -: pdq_pkg::DIG_W]};
		dig_prod = pdq_pkg::DIG_PROD_W'(trial) * pdq_pkg::DIG_PROD_W'(pdq_pkg::FRAC_RECIP);
		q_dig    = pdq_pkg::DIG_W'(dig_prod >> pdq_pkg::FRAC_SHIFT);
		rem_next = pdq_pkg::REM_W'(trial
			- TRIAL_W'(q_dig) * TRIAL_W'(pdq_pkg::PCT_DIVISOR));
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			quo_q <= DIV_W'(cfg_wdata[VAL_W-1:0]);
			rem_q <= '0;
		end else if (cal_ctl.div_step) begin
			quo_q <= {quo_q[DIV_W-pdq_pkg::DIG_W-1:0], q_dig};
			rem_q <= rem_next;
		end
	end

	// ------------------------------------------------------------------
	// Domain limits: floor(B*p/100) = (B/100)*p + floor((B%100)*p/100).
	// The second term multiplies by p*reciprocal, a single constant.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0]               q_part    [DOMAIN_COUNT];
	logic [pdq_pkg::FRAC_PROD_W-1:0] frac_prod [DOMAIN_COUNT];
	logic [VAL_W-1:0]                lim_calc  [DOMAIN_COUNT];
	logic [SCL_W-1:0]                lim9_calc [DOMAIN_COUNT];
	logic [VAL_W-1:0]                limit_q   [DOMAIN_COUNT];
	logic [SCL_W-1:0]                lim9_q    [DOMAIN_COUNT];

	always_comb begin
		for (int i = 0; i < DOMAIN_COUNT; i++) begin
			q_part[i]    = PROD_W'(quo_q[VAL_W-1:0]) * PROD_W'(pdq_pkg::SHARE_PCT[i]);
			frac_prod[i] = pdq_pkg::FRAC_PROD_W'(rem_q)
				* pdq_pkg::FRAC_PROD_W'(pdq_pkg::SHARE_PCT[i] * pdq_pkg::FRAC_RECIP);
			lim_calc[i]  = VAL_W'(q_part[i]
				+ PROD_W'(frac_prod[i] >> pdq_pkg::FRAC_SHIFT));
			lim9_calc[i] = SCL_W'(limit_q[i]) * SCL_W'(pdq_pkg::CRIT_LIM_MUL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DOMAIN_COUNT; i++) begin
				limit_q[i] <= '0;
				lim9_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < DOMAIN_COUNT; i++) begin
				if (cal_ctl.lim_load) begin
					limit_q[i] <= lim_calc[i];
				end
				if (cal_ctl.lim9_load) begin
					lim9_q[i] <= lim9_calc[i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Request input register
	// ------------------------------------------------------------------
	logic                               valid_s1;
	logic                               new_frame_s1;
	logic [pdq_pkg::DOMAIN_FIELD_W-1:0] dom_s1;
	logic [VAL_W-1:0]                   req_bytes_s1;
	logic                               valid_s2;
	logic                               fire_s1;
	logic                               req_fire;

	// Advance stage 1 when the result register is empty or being drained.
	assign fire_s1   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !cal_ctl.busy && (!valid_s1 || fire_s1);
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			new_frame_s1 <= req.new_frame;
			dom_s1       <= req.domain;
			req_bytes_s1 <= req.request_bytes[VAL_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Evaluate: select the domain, test the fit, update usage
	// ------------------------------------------------------------------
	logic [VAL_W-1:0]         budget_q;
	logic [VAL_W-1:0]         tot_rem_q;
	logic [VAL_W-1:0]         used_q [DOMAIN_COUNT];
	logic [DOMAIN_COUNT-1:0]  sel_hit;
	logic                     dom_in_range;
	logic [VAL_W-1:0]         used_sel;
	logic [VAL_W-1:0]         lim_sel;
	logic [SCL_W-1:0]         lim9_sel;
	logic [VAL_W-1:0]         used_base;
	logic [VAL_W:0]           used_sum;
	logic                     fit;
	logic [VAL_W-1:0]         used_new;
	logic [VAL_W-1:0]         dom_rem;
	logic [SCL_W-1:0]         used10;
	logic                     crit;
	logic [VAL_W-1:0]         tot_base;
	logic [VAL_W-1:0]         tot_new;

	always_comb begin
		used_sel = '0;
		lim_sel  = '0;
		lim9_sel = '0;
		for (int i = 0; i < DOMAIN_COUNT; i++) begin
			sel_hit[i] = int'(dom_s1) == i;
			if (sel_hit[i]) begin
				used_sel = used_q[i];
				lim_sel  = limit_q[i];
				lim9_sel = lim9_q[i];
			end
		end
		// Domains past the last one are never charged and read as zero.
		dom_in_range = int'(dom_s1) < DOMAIN_COUNT;

		used_base = new_frame_s1 ? '0 : used_sel;
		used_sum  = {1'b0, used_base} + {1'b0, req_bytes_s1};
		fit       = dom_in_range && (used_sum <= {1'b0, lim_sel});
		used_new  = fit ? used_sum[VAL_W-1:0] : used_base;

		// Usage never passes the limit, so the difference cannot wrap.
		dom_rem = lim_sel - used_new;
		used10  = SCL_W'(used_new) * SCL_W'(pdq_pkg::CRIT_USE_MUL);
		crit    = used10 > lim9_sel;

		tot_base = new_frame_s1 ? budget_q : tot_rem_q;
		tot_new  = fit ? tot_base - req_bytes_s1 : tot_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q  <= '0;
			tot_rem_q <= '0;
			for (int i = 0; i < DOMAIN_COUNT; i++) begin
				used_q[i] <= '0;
			end
		end else if (cfg_we) begin
			// New budget: drop all usage.
			budget_q  <= cfg_wdata[VAL_W-1:0];
			tot_rem_q <= cfg_wdata[VAL_W-1:0];
			for (int i = 0; i < DOMAIN_COUNT; i++) begin
				used_q[i] <= '0;
			end
		end else if (fire_s1) begin
			tot_rem_q <= tot_new;
			for (int i = 0; i < DOMAIN_COUNT; i++) begin
				if (new_frame_s1) begin
					used_q[i] <= '0;
				end
				if (fit && sel_hit[i]) begin
					used_q[i] <= used_new;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic             granted_s2;
	logic [VAL_W-1:0] dom_rem_s2;
	logic             crit_s2;
	logic [VAL_W-1:0] tot_rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			granted_s2 <= fit;
			dom_rem_s2 <= dom_rem;
			crit_s2    <= crit;
			tot_rem_s2 <= tot_new;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.granted          = granted_s2;
	assign rsp.domain_remaining = pdq_pkg::FIELD_W'(dom_rem_s2);
	assign rsp.domain_critical  = crit_s2;
	assign rsp.total_remaining  = pdq_pkg::FIELD_W'(tot_rem_s2);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic over_limit;
	logic s1_blocked;

	always_comb begin
		over_limit = 1'b0;
		for (int i = 0; i < DOMAIN_COUNT; i++) begin
			over_limit = over_limit || (used_q[i] > limit_q[i]);
		end
	end

	assign s1_blocked = valid_s1 && valid_s2 && !rsp.ready;

	`PDQ_ASSERT_NOW(a_busy_blocks_req, clk, arst_n, cal_ctl.busy, !req.ready, "request during calc")
	`PDQ_ASSERT_NEXT(a_cfg_starts_cal, clk, arst_n, cfg_we, cal_ctl.busy, "write did not start calc")
	`PDQ_ASSERT_NOW(a_stall_holds_s1, clk, arst_n, s1_blocked, !req.ready, "request taken while full")
	`PDQ_ASSERT_ALWAYS(a_usage_in_limit, clk, arst_n, !over_limit, "domain usage exceeds its limit")
	`PDQ_ASSERT_ALWAYS(a_total_in_budget, clk, arst_n, tot_rem_q <= budget_q, "remaining above budget")

endmodule
